// ----- hw/rtl/jis_pkg.sv -----
// shared types, codes and constants of the joint impedance supervisor
package jis_pkg;

	localparam int NUM_JOINTS = 7;
	localparam int FRAC_BITS  = 16;
	localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int PROD_W     = 64;
	localparam int SUM_W      = PROD_W - FRAC_BITS + 2;

	// configuration register indexes
	localparam logic [2:0] REG_STIFFNESS = 3'd0;
	localparam logic [2:0] REG_DAMPING   = 3'd1;
	localparam logic [2:0] REG_TORQUE    = 3'd2;
	localparam logic [2:0] REG_AUTO_ON   = 3'd3;
	localparam logic [2:0] REG_THRESHOLD = 3'd4;
	localparam logic [2:0] REG_COUNT_MAX = 3'd5;

	localparam logic [30:0] RST_STIFFNESS = 31'd65536000;
	localparam logic [30:0] RST_DAMPING   = 31'd327680;
	localparam logic [7:0]  RST_THRESHOLD = 8'd10;
	localparam logic [7:0]  RST_COUNT_MAX = 8'd20;

	// packet status
	localparam logic [1:0] PKT_NONE  = 2'd0;
	localparam logic [1:0] PKT_BAD   = 2'd1;
	localparam logic [1:0] PKT_VALID = 2'd2;

	// drive request
	localparam logic [1:0] DREQ_ON  = 2'd1;
	localparam logic [1:0] DREQ_OFF = 2'd2;

	// remote commands
	localparam logic [3:0] CMD_NONE      = 4'd0;
	localparam logic [3:0] CMD_START     = 4'd1;
	localparam logic [3:0] CMD_STOP      = 4'd2;
	localparam logic [3:0] CMD_CART      = 4'd3;
	localparam logic [3:0] CMD_AXIS      = 4'd4;
	localparam logic [3:0] CMD_POSITION  = 4'd5;
	localparam logic [3:0] CMD_SW_POS    = 4'd6;
	localparam logic [3:0] CMD_SW_CART   = 4'd7;
	localparam logic [3:0] CMD_SW_JNT    = 4'd8;
	localparam logic [3:0] CMD_SW_OTHER  = 4'd9;

	localparam logic [3:0] ACK_NONE     = 4'd0;
	localparam logic [3:0] ACK_START    = 4'd1;
	localparam logic [3:0] ACK_STOP     = 4'd2;
	localparam logic [3:0] ACK_CART     = 4'd6;
	localparam logic [3:0] ACK_AXIS     = 4'd7;
	localparam logic [3:0] ACK_POSITION = 4'd9;

	localparam logic [6:0] ECHO_NONE     = 7'd0;
	localparam logic [6:0] ECHO_START    = 7'd100;
	localparam logic [6:0] ECHO_STOP     = 7'd101;
	localparam logic [6:0] ECHO_CART     = 7'd104;
	localparam logic [6:0] ECHO_AXIS     = 7'd105;
	localparam logic [6:0] ECHO_POSITION = 7'd107;

	// control modes
	localparam logic [1:0] MODE_POS   = 2'd0;
	localparam logic [1:0] MODE_JNT   = 2'd1;
	localparam logic [1:0] MODE_CART  = 2'd2;
	localparam logic [1:0] MODE_OTHER = 2'd3;

	// interface state
	localparam logic IFACE_MONITOR = 1'b0;
	localparam logic IFACE_COMMAND = 1'b1;

	// drive kinds
	localparam logic [1:0] KIND_TORQUE  = 2'd0;
	localparam logic [1:0] KIND_HOLD    = 2'd1;
	localparam logic [1:0] KIND_GRAVITY = 2'd2;
	localparam logic [1:0] KIND_CART    = 2'd3;

	typedef struct packed {
		logic [2:0]         joint_index;
		logic [1:0]         packet_status;
		logic [3:0]         remote_command;
		logic [1:0]         drive_request;
		logic signed [31:0] joint_position;
		logic signed [31:0] joint_velocity;
		logic signed [31:0] gravity_torque;
		logic signed [31:0] target_position;
		logic [30:0]        target_stiffness;
		logic [30:0]        target_damping;
		logic signed [31:0] added_torque;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         joint_number;
		logic [1:0]         drive_kind;
		logic signed [31:0] drive_torque;
		logic signed [31:0] hold_position;
		logic               interface_state;
		logic [1:0]         control_mode;
		logic               power_on;
		logic [3:0]         ack_code;
		logic [6:0]         echo_code;
		logic               command_flag;
	} out_word_t;

endpackage

// ----- hw/rtl/joint_impedance_supervisor.sv -----
// joint impedance supervisor top level: tick supervision, brake latches and output word
//
// One joint word is accepted per clock cycle while results are taken; a result held at the
// output stalls the stages behind it. Each word passes the input register, product register
// and output register. The two gain multiplies (31 bit gain by 33 bit position
// error, 31 bit gain by 32 bit velocity) set the stage split: they sit between the input
// register and the product register, and rounding, the four-term sum and saturation
// follow in the next stage. Supervisory state (link counter, interface state, mode, drive
// power, brake latches) advances as each word leaves the input register, so back to back
// words see the state left by the word before. The output register frees itself as the
// result is taken, and each stage fills whenever the one after it is empty or moving.
module joint_impedance_supervisor import jis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_word
);

	logic [30:0]        stiff_q;
	logic [30:0]        damp_q;
	logic signed [31:0] bias_q;
	logic               auto_on_q;
	logic [7:0]         thr_q;
	logic [7:0]         cmax_q;

	logic [7:0]         link_q;
	logic               iface_q;
	logic [1:0]         mode_q;
	logic               drive_q;
	logic [1:0]         tick_pkt_q;
	logic [3:0]         ack_q;
	logic [6:0]         echo_q;
	logic               flag_q;
	logic [NUM_JOINTS-1:0] latch_q;
	logic signed [31:0] angle_q [NUM_JOINTS];

	in_word_t   word_s1;
	logic       v_s1;
	out_word_t  meta_s2;
	logic       sum_s2;
	logic       v_s2;
	out_word_t  result;
	out_word_t  out_q;
	logic       out_v_q;

	logic en_out;
	logic en_s2;
	logic en_s1;
	logic adv_s1;

	logic               valid_j;
	logic [JIDX_W-1:0]  jidx;
	logic               drive_n;
	logic               iface_n;
	logic [1:0]         mode_n;
	logic [1:0]         tp_n;
	logic [3:0]         ack_n;
	logic [6:0]         echo_n;
	logic               flag_n;
	logic [7:0]         link_n;
	logic               latch_wr;
	logic               latch_n;
	logic               angle_wr;
	logic [1:0]         kind;
	logic signed [31:0] base;
	logic signed [31:0] hold;
	logic               use_sum;
	logic [30:0]        k_sel;
	logic [30:0]        d_sel;
	logic signed [31:0] a_sel;
	logic signed [31:0] sat_torque;

	assign en_out   = !out_v_q || out_ready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign adv_s1   = v_s1 && en_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q   <= RST_STIFFNESS;
			damp_q    <= RST_DAMPING;
			bias_q    <= '0;
			auto_on_q <= 1'b1;
			thr_q     <= RST_THRESHOLD;
			cmax_q    <= RST_COUNT_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STIFFNESS: stiff_q   <= cfg_data[30:0];
				REG_DAMPING:   damp_q    <= cfg_data[30:0];
				REG_TORQUE:    bias_q    <= $signed(cfg_data);
				REG_AUTO_ON:   auto_on_q <= cfg_data[0];
				REG_THRESHOLD: thr_q     <= cfg_data[7:0];
				REG_COUNT_MAX: cmax_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			word_s1 <= in_word;
		end
	end

	// supervisory update and joint decision
	always_comb begin
		valid_j  = 32'(word_s1.joint_index) < NUM_JOINTS;
		jidx     = word_s1.joint_index[JIDX_W-1:0];
		drive_n  = drive_q;
		iface_n  = iface_q;
		mode_n   = mode_q;
		tp_n     = tick_pkt_q;
		ack_n    = ack_q;
		echo_n   = echo_q;
		flag_n   = flag_q;
		link_n   = link_q;
		latch_wr = 1'b0;
		latch_n  = 1'b1;
		angle_wr = 1'b0;
		kind     = KIND_GRAVITY;
		base     = word_s1.gravity_torque;
		hold     = '0;
		use_sum  = 1'b0;
		k_sel    = stiff_q;
		d_sel    = damp_q;
		a_sel    = bias_q;

		if (word_s1.drive_request == DREQ_ON) begin
			drive_n = 1'b1;
		end else if (word_s1.drive_request == DREQ_OFF) begin
			drive_n  = 1'b0;
			angle_wr = valid_j;
		end

		if (word_s1.joint_index == 3'd0) begin
			flag_n = 1'b0;
			if (link_q <= thr_q) begin
				iface_n = IFACE_MONITOR;
				drive_n = 1'b0;
			end else if (auto_on_q) begin
				drive_n = 1'b1;
				iface_n = IFACE_COMMAND;
			end
			tp_n = word_s1.packet_status;
			if (word_s1.packet_status == PKT_VALID &&
			    word_s1.remote_command != CMD_NONE) begin
				flag_n = 1'b1;
				ack_n  = ACK_NONE;
				echo_n = ECHO_NONE;
				case (word_s1.remote_command)
					CMD_START: begin
						if (drive_n) iface_n = IFACE_COMMAND;
						ack_n  = ACK_START;
						echo_n = ECHO_START;
					end
					CMD_STOP: begin
						iface_n = IFACE_MONITOR;
						ack_n   = ACK_STOP;
						echo_n  = ECHO_STOP;
					end
					CMD_CART: begin
						mode_n = MODE_CART;
						ack_n  = ACK_CART;
						echo_n = ECHO_CART;
					end
					CMD_AXIS: begin
						mode_n = MODE_JNT;
						ack_n  = ACK_AXIS;
						echo_n = ECHO_AXIS;
					end
					CMD_POSITION: begin
						mode_n = MODE_POS;
						ack_n  = ACK_POSITION;
						echo_n = ECHO_POSITION;
					end
					CMD_SW_POS:   mode_n = MODE_POS;
					CMD_SW_CART:  mode_n = MODE_CART;
					CMD_SW_JNT:   mode_n = MODE_JNT;
					CMD_SW_OTHER: mode_n = MODE_OTHER;
					default: ;
				endcase
			end
			if (tp_n == PKT_VALID) begin
				if (link_q < cmax_q) link_n = link_q + 8'd1;
			end else if (tp_n != PKT_BAD) begin
				if (link_q != 8'd0) link_n = link_q - 8'd1;
			end
		end

		if (mode_n == MODE_JNT) begin
			k_sel = word_s1.target_stiffness;
			d_sel = word_s1.target_damping;
			a_sel = word_s1.added_torque;
		end

		if (valid_j) begin
			kind = KIND_HOLD;
			if (tp_n == PKT_VALID && drive_n) begin
				if (mode_n == MODE_POS || mode_n == MODE_JNT) begin
					if (iface_n == IFACE_COMMAND) begin
						kind     = KIND_TORQUE;
						use_sum  = 1'b1;
						latch_wr = 1'b1;
						latch_n  = 1'b0;
					end
				end else if (mode_n == MODE_CART) begin
					kind     = KIND_CART;
					base     = '0;
					latch_wr = 1'b1;
					latch_n  = 1'b0;
				end else begin
					kind = KIND_GRAVITY;
				end
			end
			if (kind == KIND_HOLD) begin
				if (!latch_q[jidx]) begin
					angle_wr = 1'b1;
					latch_wr = 1'b1;
					latch_n  = 1'b1;
				end
				hold = angle_wr ? word_s1.joint_position : angle_q[jidx];
			end
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q     <= '0;
			iface_q    <= IFACE_MONITOR;
			mode_q     <= MODE_POS;
			drive_q    <= 1'b0;
			tick_pkt_q <= PKT_NONE;
			ack_q      <= ACK_NONE;
			echo_q     <= ECHO_NONE;
			flag_q     <= 1'b0;
			latch_q    <= '1;
			for (int i = 0; i < NUM_JOINTS; i++) begin
				angle_q[i] <= '0;
			end
		end else if (adv_s1) begin
			link_q     <= link_n;
			iface_q    <= iface_n;
			mode_q     <= mode_n;
			drive_q    <= drive_n;
			tick_pkt_q <= tp_n;
			ack_q      <= ack_n;
			echo_q     <= echo_n;
			flag_q     <= flag_n;
			if (latch_wr) latch_q[jidx] <= latch_n;
			if (angle_wr) angle_q[jidx] <= word_s1.joint_position;
		end
	end

	jis_torque u_torque (
		.clk       (clk),
		.load      (adv_s1),
		.stiffness (k_sel),
		.damping   (d_sel),
		.bias      (a_sel),
		.gravity   (word_s1.gravity_torque),
		.target    (word_s1.target_position),
		.position  (word_s1.joint_position),
		.velocity  (word_s1.joint_velocity),
		.torque    (sat_torque)
	);

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			meta_s2.joint_number    <= word_s1.joint_index;
			meta_s2.drive_kind      <= kind;
			meta_s2.drive_torque    <= base;
			meta_s2.hold_position   <= hold;
			meta_s2.interface_state <= iface_n;
			meta_s2.control_mode    <= mode_n;
			meta_s2.power_on        <= drive_n;
			meta_s2.ack_code        <= ack_n;
			meta_s2.echo_code       <= echo_n;
			meta_s2.command_flag    <= flag_n;
			sum_s2                  <= use_sum;
		end
	end

	always_comb begin
		result = meta_s2;
		if (sum_s2) result.drive_torque = sat_torque;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			out_q <= result;
		end
	end

	assign out_valid = out_v_q;
	assign out_word  = out_q;

endmodule

// ----- hw/rtl/jis_torque.sv -----
// impedance torque datapath: products, rounding, sum and saturation
module jis_torque import jis_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic [30:0]        stiffness,
	input  logic [30:0]        damping,
	input  logic signed [31:0] bias,
	input  logic signed [31:0] gravity,
	input  logic signed [31:0] target,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	output logic signed [31:0] torque
);

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0]  POS_MAX = SUM_W'(32'sh7FFF_FFFF);
	localparam logic signed [SUM_W-1:0]  NEG_MAX = -(SUM_W'(32'sh7FFF_FFFF)) - SUM_W'(1);

	logic signed [32:0]           diff;
	logic signed [31:0]           kx;
	logic signed [31:0]           dx;
	logic signed [PROD_W-1:0]     pk_c;
	logic signed [PROD_W-1:0]     pd_c;
	logic signed [PROD_W-1:0]     pk_s2;
	logic signed [PROD_W-1:0]     pd_s2;
	logic signed [31:0]           bias_s2;
	logic signed [31:0]           grav_s2;
	logic signed [PROD_W-1:0]     rk_full;
	logic signed [PROD_W-1:0]     rd_full;
	logic signed [SUM_W-1:0]      sum;

	assign diff = $signed({target[31], target}) - $signed({position[31], position});
	assign kx   = $signed({1'b0, stiffness});
	assign dx   = $signed({1'b0, damping});
	assign pk_c = kx * diff;
	assign pd_c = dx * velocity;

	always_ff @(posedge clk) begin
		if (load) begin
			pk_s2   <= pk_c;
			pd_s2   <= pd_c;
			bias_s2 <= bias;
			grav_s2 <= gravity;
		end
	end

	assign rk_full = (pk_s2 + HALF) >>> FRAC_BITS;
	assign rd_full = (pd_s2 + HALF) >>> FRAC_BITS;
	assign sum = SUM_W'(rk_full) - SUM_W'(rd_full) + SUM_W'(bias_s2) + SUM_W'(grav_s2);

	always_comb begin
		if (sum > POS_MAX) begin
			torque = 32'sh7FFF_FFFF;
		end else if (sum < NEG_MAX) begin
			torque = 32'sh8000_0000;
		end else begin
			torque = sum[31:0];
		end
	end

endmodule

// ----- test/tb_top.sv -----
// testbench for joint_impedance_supervisor: directed words and random joint ticks checked against a scoreboard
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import jis_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] DREQ_IDLE  = 2'd0;
	localparam logic [1:0] DREQ_SPARE = 2'd3;
	localparam logic [1:0] PKT_SPARE  = 2'd3;
	localparam logic [3:0] CMD_UNKNOWN = 4'd10;
	localparam logic [3:0] CMD_TOP     = 4'd15;
	localparam bit signed [71:0] TQ_MAX = 72'sh7FFF_FFFF;
	localparam bit signed [71:0] TQ_MIN = -72'sh8000_0000;
	localparam logic [31:0] Q_EXTREMES [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_style_t;

	class drive_scoreboard;
		bit [30:0] stiff, damp;
		bit signed [31:0] torque_add;
		bit auto_on;
		bit [7:0] thr, cnt_max, link_cnt;
		bit iface, powered, cmd_flag;
		bit [1:0] mode, tick_pkt;
		bit latched [NUM_JOINTS];
		bit [31:0] angle [NUM_JOINTS];
		bit [3:0] ack;
		bit [6:0] echo;
		out_word_t expected_drive_q[$];
		int errors;

		function new();
			stiff = RST_STIFFNESS;
			damp = RST_DAMPING;
			torque_add = 0;
			auto_on = 1'b1;
			thr = RST_THRESHOLD;
			cnt_max = RST_COUNT_MAX;
			link_cnt = 0;
			iface = IFACE_MONITOR;
			mode = MODE_POS;
			powered = 1'b0;
			foreach (latched[i]) begin
				latched[i] = 1'b1;
				angle[i] = 0;
			end
			tick_pkt = PKT_NONE;
			ack = ACK_NONE;
			echo = ECHO_NONE;
			cmd_flag = 1'b0;
			errors = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_STIFFNESS: stiff = v[30:0];
				REG_DAMPING:   damp = v[30:0];
				REG_TORQUE:    torque_add = v;
				REG_AUTO_ON:   auto_on = v[0];
				REG_THRESHOLD: thr = v[7:0];
				REG_COUNT_MAX: cnt_max = v[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_drive_q.size();
		endfunction

		function void predict_drive(in_word_t w);
			out_word_t r;
			bit [2:0] j;
			bit valid_j, brake;
			bit signed [71:0] gain_k, gain_d, bias, half, term_k, term_d, total;
			j = w.joint_index;
			valid_j = j < NUM_JOINTS;
			if (w.drive_request == DREQ_ON) begin
				powered = 1'b1;
			end else if (w.drive_request == DREQ_OFF) begin
				powered = 1'b0;
				if (valid_j)
					angle[j] = w.joint_position;
			end
			if (j == 0) begin
				cmd_flag = 1'b0;
				if (link_cnt <= thr) begin
					iface = IFACE_MONITOR;
					powered = 1'b0;
				end else if (auto_on) begin
					powered = 1'b1;
					iface = IFACE_COMMAND;
				end
				tick_pkt = w.packet_status;
				if (tick_pkt == PKT_VALID && w.remote_command != CMD_NONE) begin
					cmd_flag = 1'b1;
					case (w.remote_command)
						CMD_START: begin
							if (powered)
								iface = IFACE_COMMAND;
							ack = ACK_START;
							echo = ECHO_START;
						end
						CMD_STOP: begin
							iface = IFACE_MONITOR;
							ack = ACK_STOP;
							echo = ECHO_STOP;
						end
						CMD_CART: begin
							mode = MODE_CART;
							ack = ACK_CART;
							echo = ECHO_CART;
						end
						CMD_AXIS: begin
							mode = MODE_JNT;
							ack = ACK_AXIS;
							echo = ECHO_AXIS;
						end
						CMD_POSITION: begin
							mode = MODE_POS;
							ack = ACK_POSITION;
							echo = ECHO_POSITION;
						end
						CMD_SW_POS:   mode = MODE_POS;
						CMD_SW_CART:  mode = MODE_CART;
						CMD_SW_JNT:   mode = MODE_JNT;
						CMD_SW_OTHER: mode = MODE_OTHER;
						default: ;
					endcase
					// mode switches and unknown codes clear the acknowledge
					if (w.remote_command >= CMD_SW_POS) begin
						ack = ACK_NONE;
						echo = ECHO_NONE;
					end
				end
			end

			r = '0;
			r.joint_number = j;
			r.drive_kind = KIND_HOLD;
			r.drive_torque = w.gravity_torque;
			if (!valid_j) begin
				r.drive_kind = KIND_GRAVITY;
			end else begin
				brake = 1'b1;
				if (tick_pkt == PKT_VALID && powered) begin
					if (mode == MODE_POS || mode == MODE_JNT) begin
						if (iface == IFACE_COMMAND) begin
							if (mode == MODE_POS) begin
								gain_k = stiff;
								gain_d = damp;
								bias = torque_add;
							end else begin
								gain_k = w.target_stiffness;
								gain_d = w.target_damping;
								bias = $signed(w.added_torque);
							end
							half = 72'sd1 <<< (FRAC_BITS - 1);
							term_k = gain_k * ($signed(w.target_position) - $signed(w.joint_position));
							term_k = (term_k + half) >>> FRAC_BITS;
							term_d = gain_d * $signed(w.joint_velocity);
							term_d = (term_d + half) >>> FRAC_BITS;
							total = term_k - term_d + bias + $signed(w.gravity_torque);
							if (total > TQ_MAX)
								r.drive_torque = 32'h7FFF_FFFF;
							else if (total < TQ_MIN)
								r.drive_torque = 32'h8000_0000;
							else
								r.drive_torque = total[31:0];
							r.drive_kind = KIND_TORQUE;
							latched[j] = 1'b0;
							brake = 1'b0;
						end
					end else if (mode == MODE_CART) begin
						r.drive_kind = KIND_CART;
						r.drive_torque = 0;
						latched[j] = 1'b0;
						brake = 1'b0;
					end else begin
						r.drive_kind = KIND_GRAVITY;
						brake = 1'b0;
					end
				end
				if (brake) begin
					if (!latched[j]) begin
						angle[j] = w.joint_position;
						latched[j] = 1'b1;
					end
					r.drive_kind = KIND_HOLD;
					r.hold_position = angle[j];
				end
			end

			if (j == 0) begin
				if (tick_pkt == PKT_VALID) begin
					if (link_cnt < cnt_max)
						link_cnt++;
				end else if (tick_pkt != PKT_BAD) begin
					if (link_cnt > 0)
						link_cnt--;
				end
			end
			r.interface_state = iface;
			r.control_mode = mode;
			r.power_on = powered;
			r.ack_code = ack;
			r.echo_code = echo;
			r.command_flag = cmd_flag;
			expected_drive_q = {expected_drive_q, r};
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (errors < 40)
				$display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
			errors++;
		endtask

		task check_drive(out_word_t got);
			out_word_t want;
			if (expected_drive_q.size() == 0) begin
				report("word with nothing expected", 32'(got.joint_number), 0);
				return;
			end
			want = expected_drive_q.pop_front();
			if (got.joint_number !== want.joint_number)
				report("joint_number", 32'(got.joint_number), 32'(want.joint_number));
			if (got.drive_kind !== want.drive_kind)
				report("drive_kind", 32'(got.drive_kind), 32'(want.drive_kind));
			if (got.drive_torque !== want.drive_torque)
				report("drive_torque", got.drive_torque, want.drive_torque);
			if (got.hold_position !== want.hold_position)
				report("hold_position", got.hold_position, want.hold_position);
			if (got.interface_state !== want.interface_state)
				report("interface_state", 32'(got.interface_state),
					32'(want.interface_state));
			if (got.control_mode !== want.control_mode)
				report("control_mode", 32'(got.control_mode), 32'(want.control_mode));
			if (got.power_on !== want.power_on)
				report("power_on", 32'(got.power_on), 32'(want.power_on));
			if (got.ack_code !== want.ack_code)
				report("ack_code", 32'(got.ack_code), 32'(want.ack_code));
			if (got.echo_code !== want.echo_code)
				report("echo_code", 32'(got.echo_code), 32'(want.echo_code));
			if (got.command_flag !== want.command_flag)
				report("command_flag", 32'(got.command_flag), 32'(want.command_flag));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;

	drive_scoreboard sb = new();
	int stall_cycles = 0;
	int gap_max = 0;
	int burst_left = 0;
	rx_style_t rx_style = RX_ALWAYS;
	int rx_tick = 0;
	int rx_hold = 0;

	joint_impedance_supervisor DUT (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .in_word, .out_valid, .out_ready, .out_word
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		case (rx_style)
			RX_ALWAYS:   out_ready <= 1'b1;
			RX_RANDOM:   out_ready <= ($urandom_range(3) != 0);
			RX_PERIODIC: out_ready <= (rx_tick % 7) >= 2;
			default: begin
				if (rx_hold != 0) begin
					rx_hold <= rx_hold - 1;
					out_ready <= 1'b0;
				end else if ($urandom_range(15) == 0) begin
					rx_hold <= $urandom_range(1, 10);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.predict_drive(in_word);
		if (out_valid && out_ready)
			sb.check_drive(out_word);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles > STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic logic [31:0] rand_q32();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return Q_EXTREMES[$urandom_range(3)];
		if (sel < 4)
			return $urandom_range(0, 1 << 21) - (1 << 20);
		return $urandom;
	endfunction

	function automatic logic [30:0] rand_gain();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
		if (sel < 5)
			return 31'($urandom_range(0, 1 << 23));
		return 31'($urandom);
	endfunction

	function automatic in_word_t rand_joint(logic [2:0] j);
		in_word_t w;
		w.joint_index = j;
		w.packet_status = 2'($urandom);
		w.remote_command = 4'($urandom);
		w.drive_request = ($urandom_range(15) == 0) ? 2'($urandom_range(1, 3)) : DREQ_IDLE;
		w.joint_position = rand_q32();
		w.joint_velocity = rand_q32();
		w.gravity_torque = rand_q32();
		w.target_position = rand_q32();
		w.target_stiffness = rand_gain();
		w.target_damping = rand_gain();
		w.added_torque = rand_q32();
		return w;
	endfunction

	function automatic in_word_t mk_word(logic [2:0] j, logic [1:0] pkt, logic [3:0] cmd,
			logic [1:0] dreq);
		in_word_t w;
		w = '0;
		w.joint_index = j;
		w.packet_status = pkt;
		w.remote_command = cmd;
		w.drive_request = dreq;
		w.gravity_torque = 32'h0001_2345;
		return w;
	endfunction

	task send_word(in_word_t w);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gap_max != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
		burst_left--;
		in_word <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	task reconfigure(logic [30:0] s, logic [30:0] d, logic [31:0] t, logic a,
			logic [7:0] th, logic [7:0] mx);
		drain();
		repeat (4) @(posedge clk);
		write_reg(REG_STIFFNESS, 32'(s));
		write_reg(REG_DAMPING, 32'(d));
		write_reg(REG_TORQUE, t);
		write_reg(REG_AUTO_ON, 32'(a));
		write_reg(REG_THRESHOLD, 32'(th));
		write_reg(REG_COUNT_MAX, 32'(mx));
		gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
		rx_style = rx_style_t'($urandom_range(3));
	endtask

	task send_tick();
		int r, stray_at;
		in_word_t w;
		r = $urandom_range(9);
		if (r == 0) begin
			// noise: words for arbitrary joints in no order
			repeat ($urandom_range(1, 7)) send_word(rand_joint(3'($urandom)));
		end else begin
			w = rand_joint(0);
			r = $urandom_range(99);
			if (r < 80)
				w.packet_status = PKT_VALID;
			else if (r < 90)
				w.packet_status = PKT_NONE;
			else if (r < 97)
				w.packet_status = PKT_BAD;
			else
				w.packet_status = PKT_SPARE;
			r = $urandom_range(99);
			if (r < 55)
				w.remote_command = CMD_NONE;
			else if (r < 85)
				w.remote_command = 4'($urandom_range(CMD_START, CMD_POSITION));
			else if (r < 95)
				w.remote_command = 4'($urandom_range(CMD_SW_POS, CMD_SW_OTHER));
			else
				w.remote_command = 4'($urandom_range(CMD_UNKNOWN, CMD_TOP));
			r = $urandom_range(99);
			if (r < 75)
				w.drive_request = DREQ_IDLE;
			else if (r < 88)
				w.drive_request = DREQ_ON;
			else if (r < 96)
				w.drive_request = DREQ_OFF;
			else
				w.drive_request = DREQ_SPARE;
			send_word(w);
			stray_at = ($urandom_range(9) == 0) ? $urandom_range(1, NUM_JOINTS - 1) : 0;
			for (int j = 1; j < NUM_JOINTS; j++) begin
				if (j == stray_at)
					send_word(rand_joint(3'(NUM_JOINTS)));
				send_word(rand_joint(3'(j)));
			end
		end
	endtask

	task run_ticks(int n);
		for (int t = 0; t < n; t++) begin
			if ($urandom_range(49) == 0)
				drain();
			send_tick();
		end
	endtask

	initial begin
		in_word_t w;
		logic [7:0] th;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// link down: spare packet and drive codes, drive requests, invalid joint
		send_word(mk_word(0, PKT_SPARE, CMD_START, DREQ_SPARE));
		send_word(mk_word(0, PKT_BAD, CMD_NONE, DREQ_ON));
		w = mk_word(3'(NUM_JOINTS), PKT_NONE, CMD_NONE, DREQ_OFF);
		w.gravity_torque = 32'h7FFF_FFFF;
		send_word(w);
		w = mk_word(3, PKT_NONE, CMD_NONE, DREQ_OFF);
		w.joint_position = 32'h8000_0000;
		send_word(w);
		// every nonzero command code; the link comes up partway through
		for (int c = CMD_START; c <= CMD_TOP; c++)
			send_word(mk_word(0, PKT_VALID, 4'(c), DREQ_IDLE));
		// saturation both ways in position mode, then upward in joint mode
		w = mk_word(0, PKT_VALID, CMD_POSITION, DREQ_IDLE);
		w.target_position = 32'h7FFF_FFFF;
		w.joint_position = 32'h8000_0000;
		send_word(w);
		w = mk_word(1, PKT_VALID, CMD_NONE, DREQ_IDLE);
		w.target_position = 32'h8000_0000;
		w.joint_position = 32'h7FFF_FFFF;
		w.joint_velocity = 32'h7FFF_FFFF;
		send_word(w);
		w = mk_word(0, PKT_VALID, CMD_AXIS, DREQ_IDLE);
		w.target_stiffness = 31'h7FFF_FFFF;
		w.target_damping = 31'h7FFF_FFFF;
		w.added_torque = 32'h8000_0000;
		w.joint_velocity = 32'h8000_0000;
		w.target_position = 32'h0000_0001;
		send_word(w);
		// rounding ties go toward plus infinity
		w = mk_word(2, PKT_VALID, CMD_NONE, DREQ_IDLE);
		w.target_stiffness = 31'd1;
		w.target_damping = 31'd1;
		w.target_position = 32'h0000_8000;
		w.joint_velocity = 32'hFFFF_8000;
		send_word(w);
		send_word(mk_word(0, PKT_VALID, CMD_CART, DREQ_IDLE));
		w = mk_word(2, PKT_NONE, CMD_NONE, DREQ_OFF);
		w.joint_position = 32'h1234_5678;
		send_word(w);

		gap_max = 6;
		rx_style = RX_RANDOM;
		run_ticks(35);
		reconfigure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 8'd0, 8'd255);
		run_ticks(30);
		reconfigure(31'd0, 31'd0, 32'h8000_0000, 1'b0, 8'd0, 8'd1);
		run_ticks(30);
		reconfigure(31'($urandom_range(0, 1 << 24)), 31'($urandom_range(0, 1 << 20)),
			rand_q32(), 1'b1, 8'd3, 8'd6);
		run_ticks(30);
		reconfigure(rand_gain(), rand_gain(), rand_q32(), 1'b1, 8'd255, 8'd255);
		run_ticks(10);
		th = 8'($urandom_range(8));
		reconfigure(rand_gain(), rand_gain(), rand_q32(), 1'($urandom_range(1)), th,
			8'($urandom_range(th + 1, 16)));
		run_ticks(40);
		reconfigure(RST_STIFFNESS, RST_DAMPING, 32'd0, 1'b1, RST_THRESHOLD, RST_COUNT_MAX);
		run_ticks(20);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
